// File: rtl/core/pcv_pkg.sv
// Shared types and constants for the pen polygon path convolver.
// No dependencies; used by pcv_front, pcv_queue, pcv_back.
package pcv_pkg;

  localparam int CB = 32;  // coordinate width, 16.16 fixed point

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_POINT  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_START,
    KIND_POINT
  } kind_t;

  // one classified request; a/b carry the pen offset for a load, the point otherwise
  typedef struct packed {
    kind_t         kind;
    logic [4:0]    idx;
    logic [CB-1:0] a;
    logic [CB-1:0] b;
    logic          fmark;
    logic          rmark;
    logic          dir;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
    logic          last;
  } cmd_t;

endpackage

// File: rtl/core/pen_polygon_path_convolver_top.sv
// Top level of the pen polygon path convolver.
// Depends on pcv_pkg, pcv_front, pcv_queue, pcv_back.
//
// Traces one side of a stroked path: each path point request emits outline
// points (point plus active pen vertex offset) and walks the active vertex
// around the loaded convex pen by exact cross-product slope tests. Load and
// start requests give no results; a start scans the marks vertex by vertex.
// A first point is emitted with no slope test; a point that finishes a held
// one first runs a slope test on the segment from the held point, and a last
// point adds one more end slope test. Each turn takes three reads of the pen
// table, four products through the one shared 32x32 multiplier, a compare and
// an emit. A two-entry queue lets the input keep taking requests while the
// back end works, and results wait in an output register.
module pen_polygon_path_convolver_top
  import pcv_pkg::*;
#(
  parameter int MAX_PEN_VERTICES = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [4:0]           vertex_index,
  input  logic signed [CB-1:0] pen_dx,
  input  logic signed [CB-1:0] pen_dy,
  input  logic                 forward_mark,
  input  logic                 reverse_mark,
  input  logic                 direction,
  input  logic signed [CB-1:0] point_x,
  input  logic signed [CB-1:0] point_y,
  input  logic signed [CB-1:0] end_dx,
  input  logic signed [CB-1:0] end_dy,
  input  logic                 last_point,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           pen_vertex_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CB-1:0] hull_x,
  output logic signed [CB-1:0] hull_y,
  output logic                 run_end,
  output logic                 turn_capped
);

  logic push_valid, push_ready, q_valid, q_ready;
  cmd_t push_cmd, q_cmd;

  pcv_front #(.MAX_PEN_VERTICES(MAX_PEN_VERTICES)) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .vertex_index (vertex_index),
    .pen_dx       (pen_dx),
    .pen_dy       (pen_dy),
    .forward_mark (forward_mark),
    .reverse_mark (reverse_mark),
    .direction    (direction),
    .point_x      (point_x),
    .point_y      (point_y),
    .end_dx       (end_dx),
    .end_dy       (end_dy),
    .last_point   (last_point),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  pcv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  pcv_back #(.MAX_PEN_VERTICES(MAX_PEN_VERTICES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_count   (pen_vertex_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hull_x      (hull_x),
    .hull_y      (hull_y),
    .run_end     (run_end),
    .turn_capped (turn_capped)
  );

endmodule

// File: rtl/core/pcv_front.sv
// Front end: accepts input requests, drops ones that do nothing, tags the rest.
// Depends on pcv_pkg.
module pcv_front
  import pcv_pkg::*;
#(
  parameter int MAX_PEN_VERTICES = 31
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  logic [4:0]    vertex_index,
  input  logic [CB-1:0] pen_dx,
  input  logic [CB-1:0] pen_dy,
  input  logic          forward_mark,
  input  logic          reverse_mark,
  input  logic          direction,
  input  logic [CB-1:0] point_x,
  input  logic [CB-1:0] point_y,
  input  logic [CB-1:0] end_dx,
  input  logic [CB-1:0] end_dy,
  input  logic          last_point,
  output logic          push_valid,
  input  logic          push_ready,
  output cmd_t          push_cmd
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    push_cmd.kind = KIND_POINT;
    push_cmd.a = point_x;
    push_cmd.b = point_y;
    case (action)
      ACT_LOAD: begin
        keep = (vertex_index < 5'(MAX_PEN_VERTICES));
        push_cmd.kind = KIND_LOAD;
        push_cmd.a = pen_dx;
        push_cmd.b = pen_dy;
      end
      ACT_START: begin
        keep = 1'b1;
        push_cmd.kind = KIND_START;
      end
      ACT_POINT: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    push_cmd.idx   = vertex_index;
    push_cmd.fmark = forward_mark;
    push_cmd.rmark = reverse_mark;
    push_cmd.dir   = direction;
    push_cmd.ex    = end_dx;
    push_cmd.ey    = end_dy;
    push_cmd.last  = last_point;
  end

  // dropped requests are still taken, they just never reach the queue
  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// File: rtl/core/pcv_queue.sv
// Two-entry request queue between front and back.
// Depends on pcv_pkg.
module pcv_queue
  import pcv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/core/pcv_back.sv
// Back end: pen table, vertex turning sequencer, shared multiplier, result staging.
// Depends on pcv_pkg.
module pcv_back
  import pcv_pkg::*;
#(
  parameter int MAX_PEN_VERTICES = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CB-1:0] hull_x,
  output logic signed [CB-1:0] hull_y,
  output logic                 run_end,
  output logic                 turn_capped
);

  localparam int IB = $clog2(MAX_PEN_VERTICES);
  localparam int NB = $clog2(MAX_PEN_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SC_A, S_SC_W, S_T_A, S_T_N, S_T_P, S_T_W,
    S_MUL, S_DEC, S_EM_A, S_EM_W, S_CLOSE
  } state_t;

  state_t state;

  logic [2*CB-1:0] pen_mem [MAX_PEN_VERTICES];
  logic [1:0]      mark_mem [MAX_PEN_VERTICES];
  logic [2*CB-1:0] rd_data;
  logic [1:0]      mark_rd;
  logic [IB-1:0]   raddr;

  logic [4:0]    vcount;
  logic [NB-1:0] n;
  logic [IB-1:0] active, nx, pv, scan_i;
  logic [NB-1:0] nx_w, turns;
  logic          reverse_mode, have_held, last_r;
  logic [1:0]    phase;
  logic [1:0]    mk;

  logic [CB-1:0] rd_x, rd_y;
  logic [CB-1:0] own_x, own_y, nxt_x, nxt_y;
  logic [CB-1:0] c_dx, c_dy, w_dx, w_dy, s_dx, s_dy;
  logic [CB-1:0] base_x, base_y, p_x, p_y, e_x, e_y, held_x, held_y;
  logic signed [2*CB-1:0] prod [4];
  logic signed [CB-1:0]   mul_a, mul_b;
  logic signed [2*CB-1:0] mul_p;

  logic          pend_valid, pend_closed, pend_run_end, pend_capped;
  logic [CB-1:0] pend_x, pend_y;
  logic          out_free, emit_ok, emit_now, move;
  logic          go_ccw, go_cw;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    if (vcount < 5'd2) n = NB'(2);
    else if (vcount > 5'(MAX_PEN_VERTICES)) n = NB'(MAX_PEN_VERTICES);
    else n = vcount[NB-1:0];
  end

  assign nx_w = NB'(active) + NB'(1);
  assign nx   = (nx_w == n) ? '0 : nx_w[IB-1:0];
  assign pv   = (active == '0) ? IB'(n - NB'(1)) : active - IB'(1);

  always_comb begin
    case (state)
      S_T_N:   raddr = nx;
      S_T_P:   raddr = pv;
      default: raddr = active;
    endcase
  end

  // pen table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd.kind == KIND_LOAD) begin
      pen_mem[cmd.idx[IB-1:0]]  <= {cmd.a, cmd.b};
      mark_mem[cmd.idx[IB-1:0]] <= {cmd.rmark, cmd.fmark};
    end
    rd_data <= pen_mem[raddr];
    mark_rd <= mark_mem[scan_i];
  end

  assign rd_x = rd_data[2*CB-1:CB];
  assign rd_y = rd_data[CB-1:0];

  always_comb begin
    case (mk)
      2'd0:    begin mul_a = c_dy; mul_b = s_dx; end
      2'd1:    begin mul_a = s_dy; mul_b = c_dx; end
      2'd2:    begin mul_a = w_dy; mul_b = s_dx; end
      default: begin mul_a = s_dy; mul_b = w_dx; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign go_ccw = !(prod[0] > prod[1]);
  assign go_cw  = prod[2] > prod[3];

  assign out_free = !out_valid || out_ready;
  assign emit_ok  = !pend_valid || out_free;
  assign emit_now = (state == S_EM_W) && emit_ok;
  assign move     = pend_valid && out_free && (pend_closed || emit_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vcount       <= 5'd4;
      active       <= '0;
      have_held    <= 1'b0;
      reverse_mode <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
    end else begin
      if (cfg_valid) vcount <= cfg_count;

      // result staging: the newest result waits in pend until its flags are final
      if (move) begin
        out_valid   <= 1'b1;
        hull_x      <= pend_x;
        hull_y      <= pend_y;
        run_end     <= pend_run_end;
        turn_capped <= pend_capped;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit_now) begin
        pend_valid   <= 1'b1;
        pend_closed  <= 1'b0;
        pend_run_end <= 1'b0;
        pend_capped  <= 1'b0;
        pend_x       <= base_x + rd_x;
        pend_y       <= base_y + rd_y;
      end else if (move) begin
        pend_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              KIND_START: begin
                reverse_mode <= cmd.dir;
                active       <= '0;
                scan_i       <= '0;
                have_held    <= 1'b0;
                state        <= S_SC_A;
              end
              KIND_POINT: begin
                if (NB'(active) >= n) active <= '0;
                p_x    <= cmd.a;
                p_y    <= cmd.b;
                e_x    <= cmd.ex;
                e_y    <= cmd.ey;
                last_r <= cmd.last;
                turns  <= '0;
                if (have_held) begin
                  base_x <= held_x;
                  base_y <= held_y;
                  s_dx   <= cmd.a - held_x;
                  s_dy   <= cmd.b - held_y;
                  phase  <= 2'd0;
                  state  <= S_T_A;
                end else begin
                  base_x <= cmd.a;
                  base_y <= cmd.b;
                  phase  <= 2'd1;
                  state  <= S_EM_A;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SC_A: state <= S_SC_W;
        S_SC_W: begin
          if (reverse_mode ? mark_rd[1] : mark_rd[0]) begin
            active <= scan_i;
            state  <= S_IDLE;
          end else if (NB'(scan_i) + NB'(1) >= n) begin
            state <= S_IDLE;
          end else begin
            scan_i <= scan_i + IB'(1);
            state  <= S_SC_A;
          end
        end
        S_T_A: state <= S_T_N;
        S_T_N: begin
          own_x <= rd_x;
          own_y <= rd_y;
          state <= S_T_P;
        end
        S_T_P: begin
          nxt_x <= rd_x;
          nxt_y <= rd_y;
          state <= S_T_W;
        end
        S_T_W: begin
          c_dx  <= nxt_x - own_x;
          c_dy  <= nxt_y - own_y;
          w_dx  <= own_x - rd_x;
          w_dy  <= own_y - rd_y;
          mk    <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod[mk] <= mul_p;
          mk       <= mk + 2'd1;
          if (mk == 2'd3) state <= S_DEC;
        end
        S_DEC: begin
          if ((go_ccw || go_cw) && turns < n) begin
            active <= go_ccw ? nx : pv;
            turns  <= turns + NB'(1);
            state  <= S_EM_A;
          end else begin
            if (go_ccw || go_cw) pend_capped <= 1'b1;
            if (phase == 2'd0) begin
              base_x <= p_x;
              base_y <= p_y;
              phase  <= 2'd1;
              state  <= S_EM_A;
            end else begin
              state <= S_CLOSE;
            end
          end
        end
        S_EM_A: state <= S_EM_W;
        S_EM_W: begin
          if (emit_ok) begin
            if (phase != 2'd1) begin
              state <= S_T_A;
            end else if (last_r) begin
              s_dx      <= reverse_mode ? -e_x : e_x;
              s_dy      <= reverse_mode ? -e_y : e_y;
              turns     <= '0;
              phase     <= 2'd2;
              have_held <= 1'b0;
              state     <= S_T_A;
            end else begin
              held_x    <= p_x;
              held_y    <= p_y;
              have_held <= 1'b1;
              state     <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          pend_run_end <= 1'b1;
          pend_closed  <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a cap always lands on a result already staged from this request
  a_cap_has_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC && (go_ccw || go_cw) && turns >= n) |-> pend_valid)
    else $error("turn cap with no staged result");

  a_turns_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> (turns <= n))
    else $error("turn count above vertex count");

  a_close_staged: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLOSE) |-> (pend_valid && !pend_closed))
    else $error("request closed without an open staged result");

  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_A) |-> (NB'(active) < n))
    else $error("active vertex out of range during turning");

endmodule

// File: sim/tb.sv
// Testbench for pen_polygon_path_convolver_top: random and directed requests with
// a self-checking hull point predictor. Depends on pcv_pkg and the RTL top level.
module tb
  import pcv_pkg::*;
;

  localparam int NV = 31;

  typedef struct {
    logic [1:0]         action;
    logic [4:0]         vidx;
    logic signed [31:0] pdx;
    logic signed [31:0] pdy;
    logic               fmark;
    logic               rmark;
    logic               dir;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] edx;
    logic signed [31:0] edy;
    logic               last;
  } pen_req_t;

  typedef struct {
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic               re;
    logic               tc;
  } hull_pt_t;

  class hull_tracker;
    logic signed [31:0] off_x[NV];
    logic signed [31:0] off_y[NV];
    logic [1:0]         marks[NV];
    logic [4:0]         vcount_reg;
    int                 active;
    logic signed [31:0] held_x, held_y;
    bit                 have_held;
    bit                 rev;
    hull_pt_t           hull_q[$];
    int                 step_cnt;
    int                 errors;

    function new();
      for (int i = 0; i < NV; i++) begin
        off_x[i] = 0;
        off_y[i] = 0;
        marks[i] = 0;
      end
      vcount_reg = 5'd4;
      active = 0;
      held_x = 0;
      held_y = 0;
      have_held = 0;
      rev = 0;
      errors = 0;
    endfunction

    function int nverts();
      if (vcount_reg < 2) return 2;
      return int'(vcount_reg);
    endfunction

    function bit cw(logic signed [31:0] adx, logic signed [31:0] ady,
                    logic signed [31:0] bdx, logic signed [31:0] bdy);
      return (longint'(bdy) * longint'(adx)) > (longint'(ady) * longint'(bdx));
    endfunction

    function void emit(logic signed [31:0] x, logic signed [31:0] y);
      hull_pt_t p;
      p.hx = x + off_x[active];
      p.hy = y + off_y[active];
      p.re = 0;
      p.tc = 0;
      hull_q.push_back(p);
      step_cnt++;
    endfunction

    function void walk_pen(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] sdx, logic signed [31:0] sdy);
      int n, turns, nx, pv, nxt;
      logic signed [31:0] cdx, cdy, wdx, wdy;
      n = nverts();
      turns = 0;
      while (1) begin
        nx = (active + 1 == n) ? 0 : active + 1;
        pv = (active == 0) ? n - 1 : active - 1;
        cdx = off_x[nx] - off_x[active];
        cdy = off_y[nx] - off_y[active];
        wdx = off_x[active] - off_x[pv];
        wdy = off_y[active] - off_y[pv];
        if (!cw(sdx, sdy, cdx, cdy)) nxt = nx;
        else if (cw(sdx, sdy, wdx, wdy)) nxt = pv;
        else break;
        if (turns >= n) begin
          if (step_cnt > 0) hull_q[$].tc = 1;
          break;
        end
        active = nxt;
        turns++;
        emit(x, y);
      end
    endfunction

    // accepted input request: update state, queue the hull points it yields
    function void note_request(pen_req_t r);
      int n;
      logic signed [31:0] ex, ey;
      step_cnt = 0;
      n = nverts();
      case (r.action)
        ACT_LOAD: begin
          if (r.vidx < NV) begin
            off_x[r.vidx] = r.pdx;
            off_y[r.vidx] = r.pdy;
            marks[r.vidx] = {r.rmark, r.fmark};
          end
        end
        ACT_START: begin
          rev = r.dir;
          active = 0;
          for (int i = 0; i < n; i++) begin
            if (marks[i][rev ? 1 : 0]) begin
              active = i;
              break;
            end
          end
          have_held = 0;
        end
        ACT_POINT: begin
          if (active >= n) active = 0;
          if (have_held) walk_pen(held_x, held_y, r.px - held_x, r.py - held_y);
          emit(r.px, r.py);
          if (r.last) begin
            ex = rev ? -r.edx : r.edx;
            ey = rev ? -r.edy : r.edy;
            walk_pen(r.px, r.py, ex, ey);
            have_held = 0;
          end else begin
            held_x = r.px;
            held_y = r.py;
            have_held = 1;
          end
          if (step_cnt > 0) hull_q[$].re = 1;
        end
        default: ;
      endcase
    endfunction

    function void check_point(hull_pt_t got);
      hull_pt_t want;
      if (hull_q.size() == 0) begin
        $display("%0t: unexpected hull point x=%h y=%h", $time, got.hx, got.hy);
        errors++;
        return;
      end
      want = hull_q.pop_front();
      if (got.hx !== want.hx) begin
        $display("%0t: hull_x expected %h actual %h", $time, want.hx, got.hx);
        errors++;
      end
      if (got.hy !== want.hy) begin
        $display("%0t: hull_y expected %h actual %h", $time, want.hy, got.hy);
        errors++;
      end
      if (got.re !== want.re) begin
        $display("%0t: run_end expected %b actual %b", $time, want.re, got.re);
        errors++;
      end
      if (got.tc !== want.tc) begin
        $display("%0t: turn_capped expected %b actual %b", $time, want.tc, got.tc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid, in_ready;
  logic [1:0] action;
  logic [4:0] vertex_index;
  logic signed [31:0] pen_dx, pen_dy, point_x, point_y, end_dx, end_dy;
  logic forward_mark, reverse_mark, direction, last_point;
  logic cfg_valid, cfg_ready;
  logic [4:0] cfg_count;
  logic out_valid, out_ready;
  logic signed [31:0] hull_x, hull_y;
  logic run_end, turn_capped;

  hull_tracker tracker = new();
  bit calm = 0;
  int stall_left = 0;
  int n_sent = 0;

  always #5 clk = ~clk;

  pen_polygon_path_convolver_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .vertex_index(vertex_index),
    .pen_dx(pen_dx), .pen_dy(pen_dy),
    .forward_mark(forward_mark), .reverse_mark(reverse_mark),
    .direction(direction),
    .point_x(point_x), .point_y(point_y),
    .end_dx(end_dx), .end_dy(end_dy), .last_point(last_point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pen_vertex_count(cfg_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .hull_x(hull_x), .hull_y(hull_y), .run_end(run_end), .turn_capped(turn_capped)
  );

  // result side: random stall bursts, none once calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        tracker.check_point('{hull_x, hull_y, run_end, turn_capped});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send(pen_req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1;
    action <= r.action;
    vertex_index <= r.vidx;
    pen_dx <= r.pdx;
    pen_dy <= r.pdy;
    forward_mark <= r.fmark;
    reverse_mark <= r.rmark;
    direction <= r.dir;
    point_x <= r.px;
    point_y <= r.py;
    end_dx <= r.edx;
    end_dy <= r.edy;
    last_point <= r.last;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(r);
    n_sent++;
  endtask

  function automatic pen_req_t blank_req(logic [1:0] act);
    pen_req_t r;
    r.action = act;
    r.vidx = $urandom;
    r.pdx = $urandom;
    r.pdy = $urandom;
    r.fmark = $urandom;
    r.rmark = $urandom;
    r.dir = $urandom;
    r.px = $urandom;
    r.py = $urandom;
    r.edx = $urandom;
    r.edy = $urandom;
    r.last = 0;
    return r;
  endfunction

  task automatic load_vertex(int i, logic signed [31:0] dx, logic signed [31:0] dy,
                             logic fm, logic rm);
    pen_req_t r;
    r = blank_req(ACT_LOAD);
    r.vidx = i;
    r.pdx = dx;
    r.pdy = dy;
    r.fmark = fm;
    r.rmark = rm;
    send(r);
  endtask

  // vertices on a circle stay convex for any vertex count in use
  function automatic logic signed [31:0] circ(int i, real rad, bit ysel);
    real ang;
    ang = 6.283185307 * i / NV;
    return ysel ? $rtoi(rad * $sin(ang)) : $rtoi(rad * $cos(ang));
  endfunction

  task automatic start_run(logic dir);
    pen_req_t r;
    r = blank_req(ACT_START);
    r.dir = dir;
    send(r);
  endtask

  task automatic path_point(logic signed [31:0] x, logic signed [31:0] y, logic last,
                            logic signed [31:0] ex, logic signed [31:0] ey);
    pen_req_t r;
    r = blank_req(ACT_POINT);
    r.px = x;
    r.py = y;
    r.last = last;
    r.edx = ex;
    r.edy = ey;
    send(r);
  endtask

  // wait for all hull points, then let a start scan or load finish
  task automatic drain();
    in_valid <= 0;
    while (tracker.hull_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    drain();
    cfg_valid <= 1;
    cfg_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    tracker.vcount_reg = v;
  endtask

  function automatic logic signed [31:0] small_step();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    endcase
  endfunction

  initial begin
    logic signed [31:0] x, y;
    pen_req_t r;
    int k;
    rst <= 1;
    in_valid <= 0;
    cfg_valid <= 0;
    cfg_count <= 5'd4;
    action <= ACT_LOAD;
    vertex_index <= 0;
    pen_dx <= 0;
    pen_dy <= 0;
    forward_mark <= 0;
    reverse_mark <= 0;
    direction <= 0;
    point_x <= 0;
    point_y <= 0;
    end_dx <= 0;
    end_dy <= 0;
    last_point <= 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // pen: forward mark on vertex 0 only, reverse mark on vertex 20 only
    for (int i = 0; i < NV; i++)
      load_vertex(i, circ(i, 65536.0 * 3, 0), circ(i, 65536.0 * 3, 1), i == 0, i == 20);

    // directed: reset count, simple run, zero-length segment, end slope
    start_run(0);
    path_point(32'sh10000, 32'sh10000, 0, 0, 0);
    path_point(32'sh50000, 32'sh10000, 0, 0, 0);
    path_point(32'sh50000, 32'sh10000, 0, 0, 0);
    path_point(32'sh50000, 32'sh90000, 1, 32'sh10000, 0);
    path_point(32'sh20000, 32'sh20000, 1, 0, 0);
    set_count(5'd8);
    start_run(1);  // no reverse mark below the count: vertex 0
    path_point(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    path_point(32'sh80000000, 32'sh80000000, 1, 32'sh7fffffff, 32'sh80000000);
    set_count(5'd31);
    start_run(1);
    path_point(0, 0, 0, 0, 0);
    path_point(32'sh30000, -32'sh30000, 1, -32'sh10000, 32'sh8000);
    set_count(5'd2);  // active vertex now beyond the count
    path_point(32'sh1000, 32'sh2000, 0, 0, 0);
    path_point(-32'sh1000, 32'sh2000, 1, 0, 32'sh10000);
    load_vertex(31, 32'sh7fffffff, 32'sh80000000, 1, 1);
    r = blank_req(ACT_UNUSED);
    send(r);
    set_count(5'd31);
    start_run(0);
    path_point(32'sh80000000, 32'sh7fffffff, 1, 32'sh80000000, 32'sh80000000);

    while (n_sent < 310) begin
      calm = n_sent > 280;
      k = $urandom_range(0, 99);
      if (k < 70) begin
        start_run($urandom);
        x = $urandom;
        y = $urandom;
        k = $urandom_range(1, 6);
        for (int j = 0; j < k; j++) begin
          x = x + small_step();
          y = y + small_step();
          path_point(x, y, j == k - 1, small_step(), small_step());
        end
      end else if (k < 76) begin
        case ($urandom_range(0, 3))
          0: set_count(5'd2);
          1: set_count(5'd31);
          default: set_count(5'($urandom_range(2, 31)));
        endcase
      end else if (k < 84) begin
        r = blank_req(ACT_LOAD);
        if (r.vidx != 31 && $urandom_range(0, 2) != 0) begin
          r.pdx = circ(r.vidx, 65536.0 * $urandom_range(1, 100), 0);
          r.pdy = circ(r.vidx, 65536.0 * $urandom_range(1, 100), 1);
        end
        send(r);
      end else if (k < 88) begin
        send(blank_req(ACT_UNUSED));
      end else if (k < 95) begin
        r = blank_req(ACT_POINT);
        r.last = $urandom;
        send(r);
      end else begin
        drain();
      end
    end
    in_valid <= 0;

    k = 0;
    while (tracker.hull_q.size() != 0 && k < 200000) begin
      @(posedge clk);
      k++;
    end
    repeat (150) @(posedge clk);
    if (tracker.hull_q.size() != 0) begin
      $display("%0t: %0d hull points never arrived", $time, tracker.hull_q.size());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("[pen_polygon_path_convolver_top] OK");
    else
      $display("[pen_polygon_path_convolver_top] ERROR");
    $finish;
  end

  initial begin
    #100000000;
    $display("[pen_polygon_path_convolver_top] ERROR");
    $finish;
  end

endmodule
